@@ src/ssdw_pkg.sv @@
// ----------------------------------------------------------------------------
// Seven-segment writer package
// Shared item types, digit constants and the segment code table.
// ----------------------------------------------------------------------------
package ssdw_pkg;

    localparam int DIGIT_COUNT_DEFAULT = 6;
    localparam int DIGIT_MAX           = 8;
    localparam int DIGIT_IDX_W         = 3;
    localparam int VALUE_W             = 32;

    localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;
    localparam int                 RECIP_SHIFT = 35;
    localparam logic [7:0]         POINT_BIT = 8'h80;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [2:0]         point_position;
    } t_in_item;

    typedef struct packed {
        logic [2:0] digit_register;
        logic [7:0] segment_data;
        logic       last_write;
    } t_out_item;

    typedef logic [DIGIT_MAX-1:0][3:0] t_digits;

    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] quot;
        t_digits            digits;
        logic [2:0]         point;
    } t_link;

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        case (digit)
            4'd0:    code = 8'h7E;
            4'd1:    code = 8'h30;
            4'd2:    code = 8'h6D;
            4'd3:    code = 8'h79;
            4'd4:    code = 8'h33;
            4'd5:    code = 8'h5B;
            4'd6:    code = 8'h5F;
            4'd7:    code = 8'h70;
            4'd8:    code = 8'h7F;
            4'd9:    code = 8'h7B;
            default: code = 8'h00;
        endcase
        return code;
    endfunction

endpackage

@@ src/ssdw_cell.sv @@
// ----------------------------------------------------------------------------
// Decimal digit cell
// Divides the incoming quotient by ten, stores the remainder as its own digit
// and hands the new quotient to the next cell.
// ----------------------------------------------------------------------------
module ssdw_cell #(
    parameter int INDEX = 0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ssdw_pkg::t_link i_link,
    output logic           o_ready,
    input  logic           i_ready,
    output ssdw_pkg::t_link o_link
);
    import ssdw_pkg::*;

    localparam logic [DIGIT_IDX_W-1:0] SLOT = DIGIT_IDX_W'(INDEX);

    logic                 r_valid;
    logic [VALUE_W-1:0]   r_quot;
    t_digits              r_digits;
    logic [2:0]           r_point;

    logic [2*VALUE_W-1:0] w_prod;
    logic [VALUE_W-1:0]   n_quot;
    logic [VALUE_W-1:0]   w_rem;
    t_digits              n_digits;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        w_prod   = (2*VALUE_W)'(i_link.quot) * (2*VALUE_W)'(RECIP_TEN);
        n_quot   = VALUE_W'(w_prod >> RECIP_SHIFT);
        w_rem    = i_link.quot - {n_quot[VALUE_W-4:0], 3'b000} - {n_quot[VALUE_W-2:0], 1'b0};
        n_digits = i_link.digits;
        n_digits[SLOT] = w_rem[3:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_link.valid;
        end
        if (o_ready && i_link.valid) begin
            r_quot   <= n_quot;
            r_digits <= n_digits;
            r_point  <= i_link.point;
        end
    end

    assign o_link = '{valid: r_valid, quot: r_quot, digits: r_digits, point: r_point};

endmodule

@@ src/ssdw_seq.sv @@
// ----------------------------------------------------------------------------
// Display write sequencer
// Emits the blanking writes and then the segment writes of one converted item.
// ----------------------------------------------------------------------------
module ssdw_seq #(
    parameter int DIGIT_COUNT = ssdw_pkg::DIGIT_COUNT_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ssdw_pkg::t_link    i_link,
    output logic               o_ready,
    output logic               o_valid,
    output ssdw_pkg::t_out_item o_item,
    input  logic               i_stall
);
    import ssdw_pkg::*;

    localparam int                STEP_W    = $clog2(2*DIGIT_COUNT);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(2*DIGIT_COUNT-1);
    localparam logic [STEP_W-1:0] D_STEP    = STEP_W'(DIGIT_COUNT);

    logic              r_busy;
    logic [STEP_W-1:0] r_step;
    t_digits           r_digits;
    logic [2:0]        r_point;

    logic              w_last;
    logic              w_blank;
    logic [3:0]        w_j;
    logic [3:0]        w_pos;
    logic [7:0]        w_data;

    assign w_last  = r_step == LAST_STEP;
    assign o_ready = !r_busy || (!i_stall && w_last);
    assign o_valid = r_busy;

    always_comb begin
        w_blank = r_step < D_STEP;
        w_j     = 4'(STEP_W'(r_step - D_STEP));
        if (w_blank) begin
            w_pos  = 4'(r_step) + 4'd1;
            w_data = 8'h00;
        end else begin
            w_pos  = 4'(DIGIT_COUNT) - w_j;
            w_data = seg_code(r_digits[w_j[DIGIT_IDX_W-1:0]]);
            if (r_point != 3'd0 && 4'(r_point) == w_j) begin
                w_data = w_data | POINT_BIT;
            end
        end
    end

    assign o_item = '{digit_register: w_pos[2:0], segment_data: w_data, last_write: w_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
        end else if (o_ready && i_link.valid) begin
            r_busy <= 1'b1;
            r_step <= '0;
        end else if (r_busy && !i_stall) begin
            if (w_last) begin
                r_busy <= 1'b0;
            end else begin
                r_step <= r_step + 1'b1;
            end
        end
        if (o_ready && i_link.valid) begin
            r_digits <= i_link.digits;
            r_point  <= i_link.point;
        end
    end

endmodule

@@ src/seven_segment_number_display_writer_top.sv @@
// ----------------------------------------------------------------------------
// Seven-segment number display writer
// Turns a number and a point position into display driver register writes.
// ----------------------------------------------------------------------------
// Each input item produces 2*DIGIT_COUNT writes (twelve by default): first the
// digit registers 1 to DIGIT_COUNT are blanked, then the segment codes are
// written from register DIGIT_COUNT down to 1, least significant digit first,
// with the point bit on the digit that point_position names. The value shows
// modulo 10^DIGIT_COUNT. The digits are found by a chain of DIGIT_COUNT cells,
// each dividing by ten and registering its result on the way to the output
// sequencer. The sequencer gives one write per cycle while the output is not
// stalled, and the next item converts in the chain while the current one is
// written.
module seven_segment_number_display_writer_top #(
    parameter int DIGIT_COUNT = ssdw_pkg::DIGIT_COUNT_DEFAULT
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ssdw_pkg::t_in_item  i_in_item,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output ssdw_pkg::t_out_item o_out_item,
    input  logic                i_out_stall
);
    import ssdw_pkg::*;

    t_link w_link  [DIGIT_COUNT+1];
    logic  w_ready [DIGIT_COUNT+1];

    assign w_link[0] = '{valid: i_in_valid, quot: i_in_item.value, digits: '0,
                         point: i_in_item.point_position};
    assign o_in_stall = !w_ready[0];

    for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_cell
        ssdw_cell #(
            .INDEX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_link  (w_link[k]),
            .o_ready (w_ready[k]),
            .i_ready (w_ready[k+1]),
            .o_link  (w_link[k+1])
        );
    end

    ssdw_seq #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_link  (w_link[DIGIT_COUNT]),
        .o_ready (w_ready[DIGIT_COUNT]),
        .o_valid (o_out_valid),
        .o_item  (o_out_item),
        .i_stall (i_out_stall)
    );

endmodule

@@ src/ssdw_checker.sv @@
// ----------------------------------------------------------------------------
// Seven-segment writer checker
// Port-level checks on the write stream of the display writer.
// ----------------------------------------------------------------------------
module ssdw_checker #(
    parameter int DIGIT_COUNT = ssdw_pkg::DIGIT_COUNT_DEFAULT
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input ssdw_pkg::t_out_item o_out_item,
    input logic                i_out_stall
);
    import ssdw_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("Stalled output item changed.");

    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_item.last_write |=> o_out_valid)
        else $error("Write stream paused in the middle of an item.");

    a_last_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.last_write |->
            o_out_item.digit_register == 3'd1 && o_out_item.segment_data[6:0] != 7'd0)
        else $error("Final write is not a digit code on register one.");

    a_reg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && DIGIT_COUNT < 8 |-> o_out_item.digit_register != 3'd0)
        else $error("Write to digit register zero.");

endmodule

bind seven_segment_number_display_writer_top ssdw_checker #(
    .DIGIT_COUNT (DIGIT_COUNT)
) u_ssdw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);
